@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros. Each assumes a clock named clk and an
// active-low reset named rst_n in the module that uses it.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BTL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BTL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/btl_pkg.sv @@
// ----------------------------------------------------------------------------
// btl_pkg
// Types, constants and helpers shared by the bright target locator.
// ----------------------------------------------------------------------------
`default_nettype none

package btl_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int XS_W  = COL_W + 1;   // holds an effective width
    localparam int YS_W  = ROW_W + 1;   // holds an effective height

    localparam int SIZE_W = 11;         // frame_width / frame_height registers
    localparam int PIX_W  = 8;
    localparam int OUT_W  = 10;         // target_col / target_row
    localparam int IDX_W  = 2;

    localparam logic [SIZE_W-1:0] WIDTH_RST     = SIZE_W'(150);
    localparam logic [SIZE_W-1:0] HEIGHT_RST    = SIZE_W'(50);
    localparam logic [PIX_W-1:0]  THRESHOLD_RST = PIX_W'(200);

    typedef enum logic [IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_BRIGHT_THR   = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [SIZE_W-1:0] frame_width;
        logic [SIZE_W-1:0] frame_height;
        logic [PIX_W-1:0]  bright_thr;
    } cfg_t;

    typedef struct packed {
        logic             frame_last;   // next pixel closes the frame
        logic             frame_done;   // closing pixel taken this cycle
        logic             found;
        logic [OUT_W-1:0] col;
        logic [OUT_W-1:0] row;
    } scan_out_t;

    // Zero acts as one, oversize is clamped.
    function automatic logic [XS_W-1:0] eff_width(input logic [SIZE_W-1:0] v);
        logic [XS_W-1:0] r;
        if (v == '0)
            r = XS_W'(1);
        else if (32'(v) > MAX_WIDTH)
            r = XS_W'(MAX_WIDTH);
        else
            r = XS_W'(v);
        return r;
    endfunction

    function automatic logic [YS_W-1:0] eff_height(input logic [SIZE_W-1:0] v);
        logic [YS_W-1:0] r;
        if (v == '0)
            r = YS_W'(1);
        else if (32'(v) > MAX_HEIGHT)
            r = YS_W'(MAX_HEIGHT);
        else
            r = YS_W'(v);
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/btl_scan.sv @@
// ----------------------------------------------------------------------------
// btl_scan
// Per-pixel scan state: raster position, first bright pixel, run ends along
// its row and down its column, and the held target center.
// ----------------------------------------------------------------------------
`default_nettype none

module btl_scan (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire btl_pkg::cfg_t                cfg,
    input  wire logic                         beat,
    input  wire logic [btl_pkg::PIX_W-1:0]    pixel,
    output btl_pkg::scan_out_t                status
);

    `include "assert_macros.svh"

    localparam int COL_W = btl_pkg::COL_W;
    localparam int ROW_W = btl_pkg::ROW_W;
    localparam int XS_W  = btl_pkg::XS_W;
    localparam int YS_W  = btl_pkg::YS_W;
    localparam int OUT_W = btl_pkg::OUT_W;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             seen_reg, seen_next;
    logic [COL_W-1:0] first_col_reg, first_col_next;
    logic [ROW_W-1:0] first_row_reg, first_row_next;
    logic             end_col_known_reg, end_col_known_next;
    logic [COL_W-1:0] end_col_reg, end_col_next;
    logic             end_row_known_reg, end_row_known_next;
    logic [ROW_W-1:0] end_row_reg, end_row_next;
    logic [OUT_W-1:0] held_col_reg, held_col_next;
    logic [OUT_W-1:0] held_row_reg, held_row_next;

    logic [XS_W-1:0]  w_eff;
    logic [YS_W-1:0]  h_eff;
    logic [XS_W-1:0]  col_inc;
    logic [YS_W-1:0]  row_inc;
    logic             row_end;
    logic             last_row;
    logic             hit;
    logic             dark;

    // values after this pixel, before any end-of-frame clear
    logic             seen_upd;
    logic [COL_W-1:0] first_col_upd;
    logic [ROW_W-1:0] first_row_upd;
    logic             end_col_known_upd;
    logic [COL_W-1:0] end_col_upd;
    logic             end_row_known_upd;
    logic [ROW_W-1:0] end_row_upd;

    logic [XS_W-1:0]  x2;
    logic [YS_W-1:0]  y2;
    logic [XS_W:0]    sum_col;
    logic [YS_W:0]    sum_row;
    logic [OUT_W-1:0] res_col;
    logic [OUT_W-1:0] res_row;

    assign w_eff    = btl_pkg::eff_width(cfg.frame_width);
    assign h_eff    = btl_pkg::eff_height(cfg.frame_height);
    assign col_inc  = {1'b0, col_reg} + XS_W'(1);
    assign row_inc  = {1'b0, row_reg} + YS_W'(1);
    assign row_end  = (col_inc >= w_eff);
    assign last_row = (row_inc >= h_eff);
    assign hit      = (pixel > cfg.bright_thr);
    assign dark     = (pixel < cfg.bright_thr);

    always_comb
    begin
        seen_upd          = seen_reg;
        first_col_upd     = first_col_reg;
        first_row_upd     = first_row_reg;
        end_col_known_upd = end_col_known_reg;
        end_col_upd       = end_col_reg;
        end_row_known_upd = end_row_known_reg;
        end_row_upd       = end_row_reg;
        if (!seen_reg)
        begin
            if (hit)
            begin
                seen_upd      = 1'b1;
                first_col_upd = col_reg;
                first_row_upd = row_reg;
            end
        end
        else
        begin
            if ((row_reg == first_row_reg) && !end_col_known_reg && dark)
            begin
                end_col_known_upd = 1'b1;
                end_col_upd       = col_reg;
            end
            if ((col_reg == first_col_reg) && (row_reg > first_row_reg) &&
                !end_row_known_reg && dark)
            begin
                end_row_known_upd = 1'b1;
                end_row_upd       = row_reg;
            end
        end
    end

    // center of the run: open-ended runs stop at the frame edge
    assign x2      = end_col_known_upd ? {1'b0, end_col_upd} : w_eff;
    assign y2      = end_row_known_upd ? {1'b0, end_row_upd} : h_eff;
    assign sum_col = {2'b00, first_col_upd} + {1'b0, x2};
    assign sum_row = {2'b00, first_row_upd} + {1'b0, y2};
    assign res_col = seen_upd ? OUT_W'(sum_col[XS_W:1]) : held_col_reg;
    assign res_row = seen_upd ? OUT_W'(sum_row[YS_W:1]) : held_row_reg;

    always_comb
    begin
        col_next           = col_reg;
        row_next           = row_reg;
        seen_next          = seen_reg;
        first_col_next     = first_col_reg;
        first_row_next     = first_row_reg;
        end_col_known_next = end_col_known_reg;
        end_col_next       = end_col_reg;
        end_row_known_next = end_row_known_reg;
        end_row_next       = end_row_reg;
        held_col_next      = held_col_reg;
        held_row_next      = held_row_reg;
        if (beat)
        begin
            seen_next          = seen_upd;
            first_col_next     = first_col_upd;
            first_row_next     = first_row_upd;
            end_col_known_next = end_col_known_upd;
            end_col_next       = end_col_upd;
            end_row_known_next = end_row_known_upd;
            end_row_next       = end_row_upd;
            if (!row_end)
            begin
                col_next = col_inc[COL_W-1:0];
            end
            else
            begin
                col_next = '0;
                if (!last_row)
                begin
                    row_next = row_inc[ROW_W-1:0];
                end
                else
                begin
                    row_next           = '0;
                    seen_next          = 1'b0;
                    first_col_next     = '0;
                    first_row_next     = '0;
                    end_col_known_next = 1'b0;
                    end_col_next       = '0;
                    end_row_known_next = 1'b0;
                    end_row_next       = '0;
                    held_col_next      = res_col;
                    held_row_next      = res_row;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg           <= '0;
            row_reg           <= '0;
            seen_reg          <= 1'b0;
            first_col_reg     <= '0;
            first_row_reg     <= '0;
            end_col_known_reg <= 1'b0;
            end_col_reg       <= '0;
            end_row_known_reg <= 1'b0;
            end_row_reg       <= '0;
            held_col_reg      <= '0;
            held_row_reg      <= '0;
        end
        else
        begin
            col_reg           <= col_next;
            row_reg           <= row_next;
            seen_reg          <= seen_next;
            first_col_reg     <= first_col_next;
            first_row_reg     <= first_row_next;
            end_col_known_reg <= end_col_known_next;
            end_col_reg       <= end_col_next;
            end_row_known_reg <= end_row_known_next;
            end_row_reg       <= end_row_next;
            held_col_reg      <= held_col_next;
            held_row_reg      <= held_row_next;
        end
    end

    always_comb
    begin
        status.frame_last = row_end && last_row;
        status.frame_done = beat && row_end && last_row;
        status.found      = seen_upd;
        status.col        = res_col;
        status.row        = res_row;
    end

    `BTL_ASSERT_IMP(a_col_end_after_seen, end_col_known_reg, seen_reg,
                    "row run end recorded without a bright pixel")
    `BTL_ASSERT_IMP(a_col_end_past_start, end_col_known_reg,
                    end_col_reg > first_col_reg,
                    "row run end not past first bright column")
    `BTL_ASSERT_IMP(a_row_end_past_start, end_row_known_reg,
                    end_row_reg > first_row_reg,
                    "column run end not below first bright row")

endmodule

`default_nettype wire

@@ rtl/bright_target_locator.sv @@
// ----------------------------------------------------------------------------
// bright_target_locator
// Locates the first bright blob of a grayscale frame and reports its center.
// ----------------------------------------------------------------------------
// Pixels stream in raster order, at most one beat per clock; each
// pixel is folded into the scan state in the cycle it is taken. The first
// pixel above the brightness threshold anchors the target, the first darker
// pixel to its right and below it bound it, and one result beat (found,
// target_col, target_row) leaves from an output register the cycle after the
// last pixel of the frame. When a frame holds no bright pixel the previous
// center is repeated with found low. Pixel input stalls only when the last
// pixel of a frame arrives while the previous result is still waiting
// downstream. Size registers take 0 as 1 and clamp above 1024; write config
// only when the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module bright_target_locator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // config write channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [btl_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [btl_pkg::SIZE_W-1:0]    cfg_data,
    // pixel stream
    input  wire logic                          pixel_valid,
    output logic                               pixel_stall,
    input  wire logic [btl_pkg::PIX_W-1:0]     pixel,
    // result stream
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic                               found,
    output logic [btl_pkg::OUT_W-1:0]          target_col,
    output logic [btl_pkg::OUT_W-1:0]          target_row
);

    `include "assert_macros.svh"

    btl_pkg::cfg_t      cfg_reg, cfg_next;
    btl_pkg::scan_out_t status;

    logic                         pix_beat;
    logic                         res_beat;
    logic                         result_valid_reg, result_valid_next;
    logic                         found_reg;
    logic [btl_pkg::OUT_W-1:0]    col_reg;
    logic [btl_pkg::OUT_W-1:0]    row_reg;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                btl_pkg::REG_FRAME_WIDTH:    cfg_next.frame_width    = cfg_data;
                btl_pkg::REG_FRAME_HEIGHT:   cfg_next.frame_height   = cfg_data;
                btl_pkg::REG_BRIGHT_THR:
                    cfg_next.bright_thr = cfg_data[btl_pkg::PIX_W-1:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= btl_pkg::WIDTH_RST;
            cfg_reg.frame_height <= btl_pkg::HEIGHT_RST;
            cfg_reg.bright_thr   <= btl_pkg::THRESHOLD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // only the frame-closing pixel has to wait for the output register
    assign pixel_stall = result_valid_reg && result_stall && status.frame_last;
    assign pix_beat    = pixel_valid && !pixel_stall;
    assign res_beat    = result_valid_reg && !result_stall;

    btl_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .beat   (pix_beat),
        .pixel  (pixel),
        .status (status)
    );

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (status.frame_done)
            result_valid_next = 1'b1;
        else if (res_beat)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (status.frame_done)
        begin
            found_reg <= status.found;
            col_reg   <= status.col;
            row_reg   <= status.row;
        end
    end

    assign result_valid = result_valid_reg;
    assign found        = found_reg;
    assign target_col   = col_reg;
    assign target_row   = row_reg;

    `BTL_ASSERT_NXT(a_frame_gives_result, status.frame_done, result_valid_reg,
                    "frame ended without a result beat")
    `BTL_ASSERT_IMP(a_no_overwrite, status.frame_done,
                    !(result_valid_reg && result_stall),
                    "result overwritten while still pending")

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for bright_target_locator. Pixel beats go through a
// scan predictor that tracks the anchor pixel and the right and lower edges
// of the target and queues one center per closed frame. Each result beat is
// checked against the oldest queued center. A short directed table comes
// first, then random scenes with a bright rectangle on a darker background,
// plus noise frames, dark frames, size changes inside a frame and oversize
// size words that are cut back partway into a frame. Both sides idle at
// random, and the result side holds off once for a long stretch so that the
// block fills up.
// ----------------------------------------------------------------------------
module testbench;

    localparam int IDX_W  = btl_pkg::IDX_W;
    localparam int SIZE_W = btl_pkg::SIZE_W;
    localparam int PIX_W  = btl_pkg::PIX_W;
    localparam int OUT_W  = btl_pkg::OUT_W;
    localparam int COL_W  = btl_pkg::COL_W;
    localparam int ROW_W  = btl_pkg::ROW_W;
    localparam int XS_W   = btl_pkg::XS_W;
    localparam int YS_W   = btl_pkg::YS_W;
    localparam int XSUM_W = XS_W + 1;
    localparam int YSUM_W = YS_W + 1;

    localparam int RUN_LIMIT_NS  = 5_000_000;
    localparam int SMALL_ITEMS   = 1000;
    localparam int SETTLE_CYCLES = 4;     // result is registered in the cycle after the last pixel
    localparam int DRAIN_CYCLES  = 20;
    localparam int HOLD_CYCLES   = 200;

    localparam logic [IDX_W-1:0] REG_UNMAPPED = IDX_W'(3);

    typedef struct packed {
        logic             found;
        logic [OUT_W-1:0] col;
        logic [OUT_W-1:0] row;
    } center_t;

    typedef enum logic {ROW_REG, ROW_PIXEL} row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [IDX_W-1:0]  idx;
        logic [SIZE_W-1:0] value;
        logic              typed;     // want is given here, not predicted
        center_t           want;
    } stim_row_t;

    typedef enum {SCENE_RECT, SCENE_NOISE, SCENE_DARK} scene_t;

    localparam center_t NO_CENTER = '0;
    localparam int N_DIRECTED = 35;
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{ROW_REG,   REG_UNMAPPED,              11'h7FF, 1'b0, NO_CENTER},
        // zero sizes act as one: every pixel closes a frame
        '{ROW_REG,   btl_pkg::REG_FRAME_WIDTH,  11'd0,   1'b0, NO_CENTER},
        '{ROW_REG,   btl_pkg::REG_FRAME_HEIGHT, 11'd0,   1'b0, NO_CENTER},
        // equal to threshold is not bright; nothing found yet gives zeros
        '{ROW_PIXEL, '0,                        11'd200, 1'b1, {1'b0, 10'd0, 10'd0}},
        '{ROW_PIXEL, '0,                        11'd255, 1'b1, {1'b1, 10'd0, 10'd0}},
        '{ROW_PIXEL, '0,                        11'd201, 1'b1, {1'b1, 10'd0, 10'd0}},
        '{ROW_REG,   btl_pkg::REG_BRIGHT_THR,   11'd0,   1'b0, NO_CENTER},
        '{ROW_PIXEL, '0,                        11'd0,   1'b1, {1'b0, 10'd0, 10'd0}},
        '{ROW_PIXEL, '0,                        11'd1,   1'b1, {1'b1, 10'd0, 10'd0}},
        // upper data bits ignored: threshold 255
        '{ROW_REG,   btl_pkg::REG_BRIGHT_THR,   11'h7FF, 1'b0, NO_CENTER},
        '{ROW_PIXEL, '0,                        11'd255, 1'b1, {1'b0, 10'd0, 10'd0}},
        // 4x3 frame, anchor (1,0), right edge 3, lower edge 2
        '{ROW_REG,   btl_pkg::REG_FRAME_WIDTH,  11'd4,   1'b0, NO_CENTER},
        '{ROW_REG,   btl_pkg::REG_FRAME_HEIGHT, 11'd3,   1'b0, NO_CENTER},
        '{ROW_REG,   btl_pkg::REG_BRIGHT_THR,   11'd100, 1'b0, NO_CENTER},
        '{ROW_PIXEL, '0,                        11'd10,  1'b0, NO_CENTER},
        '{ROW_PIXEL, '0,                        11'd150, 1'b0, NO_CENTER},
        '{ROW_PIXEL, '0,                        11'd100, 1'b0, NO_CENTER},
        '{ROW_PIXEL, '0,                        11'd50,  1'b0, NO_CENTER},
        '{ROW_PIXEL, '0,                        11'd20,  1'b0, NO_CENTER},
        '{ROW_PIXEL, '0,                        11'd150, 1'b0, NO_CENTER},
        '{ROW_PIXEL, '0,                        11'd20,  1'b0, NO_CENTER},
        '{ROW_PIXEL, '0,                        11'd20,  1'b0, NO_CENTER},
        '{ROW_PIXEL, '0,                        11'd30,  1'b0, NO_CENTER},
        '{ROW_PIXEL, '0,                        11'd99,  1'b0, NO_CENTER},
        '{ROW_PIXEL, '0,                        11'd255, 1'b0, NO_CENTER},
        '{ROW_PIXEL, '0,                        11'd0,   1'b1, {1'b1, 10'd2, 10'd1}},
        // dark frame, width shrinks under the column count mid-row
        '{ROW_PIXEL, '0,                        11'd0,   1'b0, NO_CENTER},
        '{ROW_PIXEL, '0,                        11'd0,   1'b0, NO_CENTER},
        '{ROW_PIXEL, '0,                        11'd0,   1'b0, NO_CENTER},
        '{ROW_REG,   btl_pkg::REG_FRAME_WIDTH,  11'd2,   1'b0, NO_CENTER},
        '{ROW_PIXEL, '0,                        11'd0,   1'b0, NO_CENTER},
        '{ROW_PIXEL, '0,                        11'd0,   1'b0, NO_CENTER},
        '{ROW_PIXEL, '0,                        11'd0,   1'b0, NO_CENTER},
        '{ROW_PIXEL, '0,                        11'd0,   1'b0, NO_CENTER},
        '{ROW_PIXEL, '0,                        11'd0,   1'b1, {1'b0, 10'd2, 10'd1}}
    };

    logic              clk;
    logic              rst_n        = 1'b0;
    logic              cfg_valid    = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index    = btl_pkg::REG_FRAME_WIDTH;
    logic [SIZE_W-1:0] cfg_data     = '0;
    logic              pixel_valid  = 1'b0;
    logic              pixel_stall;
    logic [PIX_W-1:0]  pixel        = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic              found;
    logic [OUT_W-1:0]  target_col;
    logic [OUT_W-1:0]  target_row;

    bright_target_locator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .found        (found),
        .target_col   (target_col),
        .target_row   (target_row)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // scan predictor state
    logic [SIZE_W-1:0] width_reg  = btl_pkg::WIDTH_RST;
    logic [SIZE_W-1:0] height_reg = btl_pkg::HEIGHT_RST;
    logic [PIX_W-1:0]  thr_reg    = btl_pkg::THRESHOLD_RST;
    logic [COL_W-1:0]  col_cnt    = '0;
    logic [ROW_W-1:0]  row_cnt    = '0;
    logic              bright_seen = 1'b0;
    logic [COL_W-1:0]  anchor_col = '0;
    logic [ROW_W-1:0]  anchor_row = '0;
    logic              right_known = 1'b0;
    logic [XS_W-1:0]   right_edge = '0;
    logic              lower_known = 1'b0;
    logic [YS_W-1:0]   lower_edge = '0;
    logic [OUT_W-1:0]  center_col = '0;
    logic [OUT_W-1:0]  center_row = '0;

    center_t pending_centers[$];
    int      error_count  = 0;
    int      pixels_sent  = 0;
    bit      frame_closed = 1'b0;
    bit      quiet        = 1'b0;
    bit      hold_req     = 1'b0;
    int      hold_left    = 0;

    scene_t  scene_mode = SCENE_RECT;
    int      rect_c0, rect_c1, rect_r0, rect_r1;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v, input int limit);
        if (v == '0)
            return SIZE_W'(1);
        if (int'(v) > limit)
            return SIZE_W'(limit);
        return v;
    endfunction

    // Folds one pixel into the scan; returns 1 when it closes the frame.
    function automatic bit scan_pixel(input logic [PIX_W-1:0] p, output center_t res);
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
        logic [XSUM_W-1:0] x_sum;
        logic [YSUM_W-1:0] y_sum;
        w = eff_size(width_reg, btl_pkg::MAX_WIDTH);
        h = eff_size(height_reg, btl_pkg::MAX_HEIGHT);
        res = '0;
        if (!bright_seen)
        begin
            if (p > thr_reg)
            begin
                bright_seen = 1'b1;
                anchor_col  = col_cnt;
                anchor_row  = row_cnt;
            end
        end
        else
        begin
            if (row_cnt == anchor_row && !right_known && p < thr_reg)
            begin
                right_known = 1'b1;
                right_edge  = XS_W'(col_cnt);
            end
            if (col_cnt == anchor_col && row_cnt > anchor_row && !lower_known && p < thr_reg)
            begin
                lower_known = 1'b1;
                lower_edge  = YS_W'(row_cnt);
            end
        end
        if (SIZE_W'(col_cnt) + SIZE_W'(1) < w)
        begin
            col_cnt = col_cnt + 1'b1;
            return 1'b0;
        end
        col_cnt = '0;
        if (SIZE_W'(row_cnt) + SIZE_W'(1) < h)
        begin
            row_cnt = row_cnt + 1'b1;
            return 1'b0;
        end
        if (bright_seen)
        begin
            x_sum = XSUM_W'(anchor_col) + XSUM_W'(right_known ? right_edge : w);
            y_sum = YSUM_W'(anchor_row) + YSUM_W'(lower_known ? lower_edge : h);
            center_col = x_sum[OUT_W:1];
            center_row = y_sum[OUT_W:1];
        end
        res = {bright_seen, center_col, center_row};
        row_cnt     = '0;
        bright_seen = 1'b0;
        anchor_col  = '0;
        anchor_row  = '0;
        right_known = 1'b0;
        right_edge  = '0;
        lower_known = 1'b0;
        lower_edge  = '0;
        return 1'b1;
    endfunction

    function automatic logic [PIX_W-1:0] dark_level();
        if (thr_reg == '0)
            return '0;
        return PIX_W'($urandom_range(0, thr_reg - 1));
    endfunction

    function automatic logic [PIX_W-1:0] shade(input int c, input int r);
        if (scene_mode == SCENE_NOISE || $urandom_range(99) < 4)
            return PIX_W'($urandom_range(0, 255));
        if ($urandom_range(99) < 3)
            return thr_reg;
        if (scene_mode == SCENE_RECT && c >= rect_c0 && c <= rect_c1 &&
            r >= rect_r0 && r <= rect_r1)
            return (thr_reg == 8'd255) ? 8'd255 : PIX_W'($urandom_range(thr_reg + 1, 255));
        return dark_level();
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] value, input bit typed,
                              input center_t typed_res);
        center_t res;
        if (!quiet && $urandom_range(99) < 11)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= value;
        do @(posedge clk); while (pixel_stall);
        pixels_sent++;
        frame_closed = scan_pixel(value, res);
        if (frame_closed)
            pending_centers.push_back(typed ? typed_res : res);
    endtask

    // Registers change only with no result outstanding and the block settled.
    task automatic wait_idle();
        pixel_valid <= 1'b0;
        while (pending_centers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            btl_pkg::REG_FRAME_WIDTH:  width_reg  = data;
            btl_pkg::REG_FRAME_HEIGHT: height_reg = data;
            btl_pkg::REG_BRIGHT_THR:   thr_reg    = data[PIX_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Sends pixels until the frame closes, or max_pixels if that is nonzero.
    task automatic send_frame(input int max_pixels);
        int      w;
        int      h;
        int      sent;
        int      pick;
        center_t none;
        w    = eff_size(width_reg, btl_pkg::MAX_WIDTH);
        h    = eff_size(height_reg, btl_pkg::MAX_HEIGHT);
        none = '0;
        pick = $urandom_range(99);
        scene_mode = (pick < 70) ? SCENE_RECT : (pick < 90) ? SCENE_NOISE : SCENE_DARK;
        rect_c0 = $urandom_range(0, w - 1);
        rect_c1 = $urandom_range(rect_c0, w - 1);
        rect_r0 = $urandom_range(0, h - 1);
        rect_r1 = $urandom_range(rect_r0, h - 1);
        sent = 0;
        do
        begin
            send_pixel(shade(col_cnt, row_cnt), 1'b0, none);
            sent++;
        end
        while (!frame_closed && (max_pixels == 0 || sent < max_pixels));
    endtask

    task automatic check_result();
        center_t want;
        if (pending_centers.size() == 0)
        begin
            report_mismatch("result beat with nothing expected");
            return;
        end
        want = pending_centers.pop_front();
        if (found !== want.found)
            report_mismatch($sformatf("found %b, expected %b", found, want.found));
        if (target_col !== want.col)
            report_mismatch($sformatf("target_col %0d, expected %0d", target_col, want.col));
        if (target_row !== want.row)
            report_mismatch($sformatf("target_row %0d, expected %0d", target_row, want.row));
    endtask

    // result side: check each beat, then pick the next stall
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
                check_result();
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                result_stall <= 1'b1;
            end
            else
                result_stall <= !quiet && ($urandom_range(99) < 11);
        end
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        bit                prev_reg;
        int                phase;
        int                small_items;
        int                n_frames;
        int                mark;
        int                pick;
        bit                big;
        logic [SIZE_W-1:0] w_word;
        logic [SIZE_W-1:0] h_word;
        logic [SIZE_W-1:0] t_word;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        prev_reg = 1'b0;
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (DIRECTED[i].kind == ROW_REG)
            begin
                if (!prev_reg)
                    wait_idle();
                write_reg(DIRECTED[i].idx, DIRECTED[i].value);
                prev_reg = 1'b1;
            end
            else
            begin
                send_pixel(DIRECTED[i].value[PIX_W-1:0], DIRECTED[i].typed, DIRECTED[i].want);
                prev_reg = 1'b0;
            end
        end

        small_items = 0;
        for (phase = 0; small_items < SMALL_ITEMS; phase++)
        begin
            quiet = (phase >= 10 && phase < 16);
            big   = (phase == 4 || phase == 8 || phase == 14);
            wait_idle();
            case (phase)
                0:
                begin
                    w_word = 11'd2;
                    h_word = 11'd1;
                end
                4:
                begin
                    w_word = 11'h7FF;
                    h_word = 11'd1;
                end
                8:
                begin
                    w_word = 11'd1;
                    h_word = 11'h7FF;
                end
                14:
                begin
                    w_word = 11'd1024;
                    h_word = 11'd0;
                end
                default:
                begin
                    w_word = ($urandom_range(99) < 5) ? 11'd0 : SIZE_W'($urandom_range(1, 9));
                    h_word = ($urandom_range(99) < 5) ? 11'd0 : SIZE_W'($urandom_range(1, 6));
                end
            endcase
            write_reg(btl_pkg::REG_FRAME_WIDTH, w_word);
            write_reg(btl_pkg::REG_FRAME_HEIGHT, h_word);
            if ($urandom_range(99) < 60)
            begin
                pick = $urandom_range(99);
                if (pick < 10)
                    t_word = {3'($urandom), 8'h00};
                else if (pick < 20)
                    t_word = {3'($urandom), 8'hFF};
                else
                    t_word = SIZE_W'($urandom_range(0, 2047));
                write_reg(btl_pkg::REG_BRIGHT_THR, t_word);
            end

            mark = pixels_sent;
            if (phase == 0)
            begin
                // receiver stalls long while tiny frames keep coming
                hold_req = 1'b1;
                n_frames = 30;
            end
            else
                n_frames = big ? 1 : $urandom_range(1, 4);
            for (int f = 0; f < n_frames; f++)
            begin
                if (big)
                begin
                    // long row or column cut short partway in
                    send_frame($urandom_range(20, 60));
                    wait_idle();
                    write_reg((phase == 8) ? btl_pkg::REG_FRAME_HEIGHT
                                           : btl_pkg::REG_FRAME_WIDTH,
                              SIZE_W'($urandom_range(1, 9)));
                    send_frame(0);
                end
                else if (f == 0 && $urandom_range(99) < 12)
                begin
                    // resize partway into a frame
                    send_frame($urandom_range(1,
                        int'(eff_size(width_reg, btl_pkg::MAX_WIDTH)) *
                        int'(eff_size(height_reg, btl_pkg::MAX_HEIGHT))));
                    wait_idle();
                    write_reg(($urandom_range(1) != 0) ? btl_pkg::REG_FRAME_WIDTH
                                                        : btl_pkg::REG_FRAME_HEIGHT,
                              SIZE_W'($urandom_range(0, 9)));
                end
                else
                    send_frame(0);
            end
            small_items += pixels_sent - mark;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
